// ===== rtl/psg_pkg.sv =====
// Shared types, constants and tables of the three-voice sound generator.
package psg_pkg;

    localparam int TICKS_W = 7;
    localparam int DIV_W = 8;
    localparam int ENV_STEPS = 128;
    localparam int LEVELS = 32;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 7'd5;
    localparam logic [DIV_W-1:0] DIV_RESET = 8'd4;
    // mix per tick <= 135, ticks <= 127
    localparam int MIX_W = 15;

    localparam logic [1:0] REQ_SELECT = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_SAMPLE = 2'd3;

    localparam logic CFG_TICKS = 1'b0;
    localparam logic CFG_DIV = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic tick;       // run one chip tick and accumulate
        logic clr_acc;    // clear accumulator
        logic div_start;  // load divider
        logic div_step;   // one restoring-divide step
        logic load_read;  // register read byte into result
        logic load_samp;  // register quotient into result
    } psg_cmd_t;

    typedef struct packed {
        logic div_done;
    } psg_sts_t;

    function automatic logic [5:0] level_lookup(input logic [4:0] idx);
        logic [5:0] r;
        case (idx)
            5'd0, 5'd1, 5'd2: r = 6'd0;
            5'd3, 5'd4, 5'd5: r = 6'd1;
            5'd6, 5'd7, 5'd8: r = 6'd2;
            5'd9: r = 6'd3;
            5'd10: r = 6'd3;
            5'd11: r = 6'd4;
            5'd12: r = 6'd4;
            5'd13: r = 6'd5;
            5'd14: r = 6'd6;
            5'd15: r = 6'd7;
            5'd16: r = 6'd8;
            5'd17: r = 6'd9;
            5'd18: r = 6'd10;
            5'd19: r = 6'd11;
            5'd20: r = 6'd13;
            5'd21: r = 6'd14;
            5'd22: r = 6'd16;
            5'd23: r = 6'd18;
            5'd24: r = 6'd20;
            5'd25: r = 6'd23;
            5'd26: r = 6'd26;
            5'd27: r = 6'd29;
            5'd28: r = 6'd32;
            5'd29: r = 6'd36;
            5'd30: r = 6'd40;
            default: r = 6'd45;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] read_mask(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1, 4'd3, 4'd5, 4'd13: r = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: r = 8'h1F;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

    // Envelope level for a shape at a position (closed form of the shape table)
    function automatic logic [4:0] env_level(input logic [3:0] shape,
                                             input logic [6:0] pos);
        logic       att;
        logic [4:0] ramp;
        logic [4:0] r;
        att = shape[2];
        ramp = att ? pos[4:0] : ~pos[4:0];
        if (pos < 7'd32) begin
            r = ramp;
        end else if (!shape[3]) begin
            r = 5'd0;
        end else if (shape[0]) begin
            // hold at end level, inverted if alternate
            r = (att ^ shape[1]) ? 5'd31 : 5'd0;
        end else if (shape[1]) begin
            r = pos[5] ? ~ramp : ramp;
        end else begin
            r = ramp;
        end
        return r;
    endfunction

endpackage

// ===== rtl/psg_datapath.sv =====
// Datapath: chip registers, tone/noise/envelope generators, mixer and divider.
module psg_datapath #(
    parameter int DIV_W = psg_pkg::DIV_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         req_type,
    input  logic [7:0]         bus_value,
    input  logic               req_take,
    input  logic [DIV_W-1:0]   div_value,
    input  psg_pkg::psg_cmd_t  cmd,
    output psg_pkg::psg_sts_t  sts,
    output logic [7:0]         result_value
);
    localparam int MW = psg_pkg::MIX_W;

    logic [7:0]  regs_reg [16];
    logic [7:0]  regs_next [16];
    logic [7:0]  sel_reg, sel_next;
    logic [11:0] tcnt_reg [3];
    logic [11:0] tcnt_next [3];
    logic [2:0]  tbit_reg, tbit_next;
    logic [5:0]  ncnt_reg, ncnt_next;
    logic [16:0] nshift_reg, nshift_next;
    logic        nbit_reg, nbit_next;
    logic [15:0] ecnt_reg, ecnt_next;
    logic [6:0]  epos_reg, epos_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] quo_reg, quo_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic [7:0]  res_reg, res_next;

    logic [7:0]  mix;
    logic [4:0]  elvl;
    logic [6:0]  cmp_noise;
    logic [15:0] eper;
    logic [15:0] ecnt_inc;
    logic [6:0]  epos_adv;
    logic [7:0]  rd_byte;
    logic [MW:0] trial;

    always_comb begin
        logic [11:0] per;
        logic [11:0] inc;
        logic [4:0]  vol;
        logic [4:0]  lv;
        for (int i = 0; i < 16; i++) regs_next[i] = regs_reg[i];
        sel_next = sel_reg;
        for (int i = 0; i < 3; i++) tcnt_next[i] = tcnt_reg[i];
        tbit_next = tbit_reg;
        ncnt_next = ncnt_reg;
        nshift_next = nshift_reg;
        nbit_next = nbit_reg;
        ecnt_next = ecnt_reg;
        epos_next = epos_reg;
        acc_next = acc_reg;
        mix = 8'd0;
        per = 12'd0;
        inc = 12'd0;
        vol = 5'd0;
        lv = 5'd0;

        // Bus requests
        if (req_take && req_type == psg_pkg::REQ_SELECT) sel_next = bus_value;
        if (req_take && req_type == psg_pkg::REQ_WRITE && sel_reg < 8'd16) begin
            regs_next[sel_reg[3:0]] = bus_value;
            if (sel_reg[3:0] == 4'd13) begin
                ecnt_next = 16'd0;
                epos_next = 7'd0;
            end
        end

        // Advance generators one tick
        cmp_noise = {regs_reg[6][4:0], 1'b0};
        eper = {regs_reg[12], regs_reg[11]};
        ecnt_inc = ecnt_reg + 16'd1;
        epos_adv = (epos_reg == 7'd127) ? 7'd64 : epos_reg + 7'd1;
        if (cmd.tick) begin
            for (int i = 0; i < 3; i++) begin
                per = {regs_reg[2*i+1][3:0], regs_reg[2*i]};
                inc = tcnt_reg[i] + 12'd1;
                if (inc >= per || inc == 12'd0) begin
                    tcnt_next[i] = 12'd0;
                    tbit_next[i] = ~tbit_reg[i];
                end else begin
                    tcnt_next[i] = inc;
                end
            end
            ncnt_next = ncnt_reg + 6'd1;
            if ({1'b0, ncnt_next} >= cmp_noise) begin
                ncnt_next = 6'd0;
                nshift_next = {nshift_reg[15:0], 1'b1 ^ nshift_reg[16] ^ nshift_reg[13]};
                nbit_next = nshift_next[16];
            end
            if (ecnt_inc >= eper || ecnt_inc == 16'd0) begin
                ecnt_next = 16'd0;
                epos_next = epos_adv;
            end else begin
                ecnt_next = ecnt_inc;
            end
            elvl = psg_pkg::env_level(regs_reg[13][3:0], epos_next);
            for (int i = 0; i < 3; i++) begin
                if ((tbit_next[i] | regs_reg[7][i]) & (nbit_next | regs_reg[7][i+3])) begin
                    vol = regs_reg[8+i][4:0];
                    if (vol[4]) lv = elvl;
                    else lv = (vol[3:0] != 4'd0) ? {vol[3:0], 1'b1} : 5'd0;
                    mix = mix + {2'b00, psg_pkg::level_lookup(lv)};
                end
            end
            acc_next = acc_reg + MW'(mix);
        end else begin
            elvl = 5'd0;
        end
        if (cmd.clr_acc) acc_next = '0;
    end

    // Read byte with port and mask rules
    always_comb begin
        rd_byte = 8'd0;
        if (sel_reg < 8'd16) begin
            if (sel_reg[3:0] >= 4'd14 && !regs_reg[7][{2'b11, sel_reg[0]}])
                rd_byte = 8'hFF;
            else
                rd_byte = regs_reg[sel_reg[3:0]] & psg_pkg::read_mask(sel_reg[3:0]);
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dcnt_next = dcnt_reg;
        trial = {rem_reg, quo_reg[MW-1]} - {{(MW+1-DIV_W){1'b0}}, div_value};
        if (cmd.div_start) begin
            rem_next = '0;
            quo_next = acc_reg;
            dcnt_next = 4'(MW);
        end else if (cmd.div_step) begin
            if (!trial[MW]) begin
                rem_next = trial[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[MW-2:0], quo_reg[MW-1]};
                quo_next = {quo_reg[MW-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 4'd1;
        end
        res_next = res_reg;
        if (cmd.load_read) res_next = rd_byte;
        if (cmd.load_samp) begin
            if (div_value == '0 || quo_reg > MW'(255)) res_next = 8'hFF;
            else res_next = quo_reg[7:0];
        end
    end

    assign sts.div_done = (dcnt_reg == 4'd0);
    assign result_value = res_reg;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) regs_reg[i] <= (i == 7) ? 8'hFF : 8'h00;
            sel_reg <= 8'hFF;
            for (int i = 0; i < 3; i++) tcnt_reg[i] <= 12'd0;
            tbit_reg <= 3'd0;
            ncnt_reg <= 6'd0;
            nshift_reg <= 17'h0FFFF;
            nbit_reg <= 1'b0;
            ecnt_reg <= 16'd0;
            epos_reg <= 7'd0;
            acc_reg <= '0;
            dcnt_reg <= 4'd0;
        end else begin
            regs_reg <= regs_next;
            sel_reg <= sel_next;
            tcnt_reg <= tcnt_next;
            tbit_reg <= tbit_next;
            ncnt_reg <= ncnt_next;
            nshift_reg <= nshift_next;
            nbit_reg <= nbit_next;
            ecnt_reg <= ecnt_next;
            epos_reg <= epos_next;
            acc_reg <= acc_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

endmodule

// ===== rtl/psg_controller.sv =====
// Controller: sequences ticks, division and the result handshake.
module psg_controller #(
    parameter int TICKS_W = psg_pkg::TICKS_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         req_type,
    output logic               req_take,
    input  logic [TICKS_W-1:0] ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output psg_pkg::psg_cmd_t  cmd,
    input  psg_pkg::psg_sts_t  sts
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TICK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [TICKS_W-1:0] tcnt_reg, tcnt_next;
    logic vld_reg, vld_next;
    logic kind_reg, kind_next;
    logic out_free;

    assign out_free = !vld_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && out_free;
    assign req_take = s_valid && s_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        tcnt_next = tcnt_reg;
        vld_next = vld_reg && !m_ready;
        kind_next = kind_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (req_take && req_type == psg_pkg::REQ_READ) begin
                    cmd.load_read = 1'b1;
                    vld_next = 1'b1;
                    kind_next = psg_pkg::KIND_READ;
                end else if (req_take && req_type == psg_pkg::REQ_SAMPLE) begin
                    cmd.clr_acc = 1'b1;
                    tcnt_next = ticks;
                    state_next = (ticks == '0) ? ST_DIV : ST_TICK;
                    if (ticks == '0) cmd.div_start = 1'b0;
                end
            end
            ST_TICK: begin
                cmd.tick = 1'b1;
                tcnt_next = tcnt_reg - 1'b1;
                if (tcnt_reg == TICKS_W'(1)) state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!sts.div_done) begin
                    cmd.div_step = 1'b1;
                end else if (out_free) begin
                    cmd.load_samp = 1'b1;
                    vld_next = 1'b1;
                    kind_next = psg_pkg::KIND_SAMPLE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = vld_reg;
    assign m_result_kind = kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg <= 1'b0;
            tcnt_reg <= '0;
            kind_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            tcnt_reg <= tcnt_next;
            kind_reg <= kind_next;
        end
    end

endmodule

// ===== rtl/psg_three_voice_sound_generator.sv =====
// Top level of the three-voice sound generator.
// Usage:
//   Input channel s_valid/s_ready carries s_req_type and s_bus_value:
//   select register, write data, read data, or request one sample.
//   Select and write give no result; read and sample give one result on
//   m_valid/m_ready with m_result_kind (0 read, 1 sample) and m_result_value.
//   Configuration channel cfg_valid/cfg_ready (always ready) writes
//   ticks_per_sample (index 0) or amp_divisor (index 1) from cfg_data.
// Timing:
//   Select, write and read are handled in the idle state; a read result
//   appears the cycle after acceptance.
//   A sample runs ticks_per_sample chip ticks (one chip tick per cycle),
//   then a divider load and the divider steps (one quotient bit each),
//   then registers the result; no new transaction is taken before the
//   sample result is registered.
// Reset: chip registers clear (mixer to 0xFF), selected register 0xFF,
//   ticks_per_sample 5, amp_divisor 4, no result pending.
// Stall: a result waits in the output register; a new item is accepted
//   while it is taken, and a finished sample holds until the register frees.
module psg_three_voice_sound_generator #(
    parameter int TICKS_W = psg_pkg::TICKS_W,
    parameter int DIV_W = psg_pkg::DIV_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [7:0]         s_bus_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic [7:0]         m_result_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);
    logic [TICKS_W-1:0] ticks_reg;
    logic [DIV_W-1:0]   div_reg;
    logic               req_take;
    psg_pkg::psg_cmd_t  cmd;
    psg_pkg::psg_sts_t  sts;

    assign cfg_ready = 1'b1;

    // Store configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= psg_pkg::TICKS_RESET;
            div_reg <= psg_pkg::DIV_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == psg_pkg::CFG_TICKS) ticks_reg <= cfg_data[TICKS_W-1:0];
            else div_reg <= cfg_data[DIV_W-1:0];
        end
    end

    psg_controller #(.TICKS_W(TICKS_W)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .req_type(s_req_type),
        .req_take(req_take), .ticks(ticks_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .cmd(cmd), .sts(sts)
    );

    psg_datapath #(.DIV_W(DIV_W)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .req_type(s_req_type), .bus_value(s_bus_value), .req_take(req_take),
        .div_value(div_reg), .cmd(cmd), .sts(sts), .result_value(m_result_value)
    );

endmodule

// ===== rtl/psg_checker.sv =====
// Port-level checker for the sound generator, bound to the top level.
module psg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_result_kind,
    input logic [7:0] m_result_value
);
    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_result_kind))
        else $error("result changed under stall");

    // Read transaction yields a read result next cycle
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == psg_pkg::REQ_READ |=>
            m_valid && m_result_kind == psg_pkg::KIND_READ)
        else $error("read result missing");

    // Sample request blocks input next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == psg_pkg::REQ_SAMPLE |=> !s_ready)
        else $error("input taken during sample");

    // Select produces no result
    a_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == psg_pkg::REQ_SELECT && !m_valid
            |=> !m_valid)
        else $error("select produced a result");
endmodule

bind psg_three_voice_sound_generator psg_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_req_type(s_req_type), .m_valid(m_valid), .m_ready(m_ready),
    .m_result_kind(m_result_kind), .m_result_value(m_result_value)
);

// ===== tb/sv/psg_three_voice_sound_generator_tb.sv =====
// Self-checking testbench of the three-voice sound generator.
module psg_three_voice_sound_generator_tb;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } psg_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_req_type;
    logic [7:0] s_bus_value;
    logic       m_valid;
    logic       m_ready;
    logic       m_result_kind;
    logic [7:0] m_result_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // predictor state
    logic [6:0]  p_ticks;
    logic [7:0]  p_div;
    logic [7:0]  p_regs [16];
    logic [7:0]  p_sel;
    logic [11:0] p_tone_cnt [3];
    logic [2:0]  p_tone_bit;
    logic [5:0]  p_noise_cnt;
    logic [16:0] p_noise_lfsr;
    logic        p_noise_bit;
    logic [15:0] p_env_cnt;
    logic [6:0]  p_env_pos;
    logic [4:0]  shape_levels [16][128];

    psg_result_t expected_results[$];
    int          mismatches;
    int          reads_seen;
    int          samples_seen;
    int          idle_send_pct;
    int          stall_recv_pct;
    int          quiet_cycles;

    psg_three_voice_sound_generator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_bus_value   (s_bus_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_result_value(m_result_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Build the sixteen envelope shapes by walking each ramp
    function automatic void build_shape_levels();
        int lvl, dir, held;
        for (int sh = 0; sh < 16; sh++) begin
            held = 0;
            dir = sh[2] ? 1 : -1;
            lvl = sh[2] ? -1 : 32;
            for (int pos = 0; pos < 128; pos++) begin
                if (!held) begin
                    lvl += dir;
                    if (lvl < 0 || lvl >= 32) begin
                        if (sh[3]) begin
                            if (sh[1]) dir = -dir;
                            lvl = (dir > 0) ? 0 : 31;
                            if (sh[0]) begin
                                held = 1;
                                lvl = (dir > 0) ? 31 : 0;
                            end
                        end else begin
                            lvl = 0;
                            held = 1;
                        end
                    end
                end
                shape_levels[sh][pos] = lvl[4:0];
            end
        end
    endfunction

    function automatic int chip_level(input logic [4:0] idx);
        int lv [32] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 4, 4, 5, 6, 7,
                        8, 9, 10, 11, 13, 14, 16, 18, 20, 23, 26, 29, 32, 36, 40, 45};
        return lv[idx];
    endfunction

    function automatic void reset_chip_state();
        p_ticks = psg_pkg::TICKS_RESET;
        p_div = psg_pkg::DIV_RESET;
        foreach (p_regs[i]) p_regs[i] = 8'h00;
        p_regs[7] = 8'hFF;
        p_sel = 8'hFF;
        foreach (p_tone_cnt[i]) p_tone_cnt[i] = '0;
        p_tone_bit = '0;
        p_noise_cnt = '0;
        p_noise_lfsr = 17'h0FFFF;
        p_noise_bit = 1'b0;
        p_env_cnt = '0;
        p_env_pos = '0;
    endfunction

    // Advance the chip one tick and return the mixed level
    function automatic int chip_tick();
        int mix;
        int period;
        int vr;
        int lvl;
        logic [4:0] env_lvl;
        logic fb;
        mix = 0;
        for (int i = 0; i < 3; i++) begin
            period = {p_regs[2*i+1][3:0], p_regs[2*i]};
            p_tone_cnt[i] = p_tone_cnt[i] + 12'd1;
            if (p_tone_cnt[i] >= period || p_tone_cnt[i] == 0) begin
                p_tone_cnt[i] = '0;
                p_tone_bit[i] = ~p_tone_bit[i];
            end
        end
        p_noise_cnt = p_noise_cnt + 6'd1;
        if (int'(p_noise_cnt) >= 2 * int'(p_regs[6][4:0])) begin
            fb = p_noise_lfsr[16] ^ p_noise_lfsr[13];
            p_noise_cnt = '0;
            p_noise_lfsr = {p_noise_lfsr[15:0], 1'b1 ^ fb};
            p_noise_bit = p_noise_lfsr[16];
        end
        if (int'(p_env_cnt) + 1 >= int'({p_regs[12], p_regs[11]})) begin
            p_env_cnt = '0;
            p_env_pos = (p_env_pos == 7'd127) ? 7'd64 : p_env_pos + 7'd1;
        end else begin
            p_env_cnt = p_env_cnt + 16'd1;
        end
        env_lvl = shape_levels[p_regs[13][3:0]][p_env_pos];
        for (int i = 0; i < 3; i++) begin
            if ((p_tone_bit[i] | p_regs[7][i]) && (p_noise_bit | p_regs[7][i+3])) begin
                vr = p_regs[8+i];
                if (vr[4]) lvl = env_lvl;
                else lvl = (vr[3:0] != 0) ? 2 * vr[3:0] + 1 : 0;
                mix += chip_level(lvl[4:0]);
            end
        end
        return mix;
    endfunction

    // Apply one accepted request and queue the result it yields
    function automatic void predict_request(input logic [1:0] req, input logic [7:0] val);
        psg_result_t r;
        int mix;
        int q;
        case (req)
            psg_pkg::REQ_SELECT: p_sel = val;
            psg_pkg::REQ_WRITE: begin
                if (p_sel < 16) begin
                    p_regs[p_sel[3:0]] = val;
                    if (p_sel == 13) begin
                        p_env_pos = '0;
                        p_env_cnt = '0;
                    end
                end
            end
            psg_pkg::REQ_READ: begin
                r.kind = psg_pkg::KIND_READ;
                r.value = 8'h00;
                if (p_sel < 16) begin
                    if (p_sel >= 14 && !p_regs[7][p_sel - 8]) r.value = 8'hFF;
                    else r.value = p_regs[p_sel[3:0]] & psg_pkg::read_mask(p_sel[3:0]);
                end
                expected_results.push_back(r);
            end
            default: begin
                mix = 0;
                for (int t = 0; t < p_ticks; t++) mix += chip_tick();
                if (p_div == 0) q = 255;
                else q = mix / p_div;
                r.kind = psg_pkg::KIND_SAMPLE;
                r.value = (q > 255) ? 8'hFF : q[7:0];
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // Send one transaction, with random idle cycles before it
    task automatic send_request(input logic [1:0] req, input logic [7:0] val);
        while ($urandom_range(99) < idle_send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_bus_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req, val);
    endtask

    // Drop the input and wait for every expected result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Write one setting while the block is idle
    task automatic write_setting(input logic idx, input logic [7:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == psg_pkg::CFG_TICKS) p_ticks = val[6:0];
        else p_div = val;
    endtask

    task automatic write_chip(input logic [7:0] idx, input logic [7:0] val);
        send_request(psg_pkg::REQ_SELECT, idx);
        send_request(psg_pkg::REQ_WRITE, val);
    endtask

    task automatic test_directed();
        write_chip(8'd1, 8'hFF);
        send_request(psg_pkg::REQ_READ, 8'h00);
        write_chip(8'd6, 8'hFF);
        send_request(psg_pkg::REQ_READ, 8'hFF);
        write_chip(8'd7, 8'h00);
        send_request(psg_pkg::REQ_SELECT, 8'd14);
        send_request(psg_pkg::REQ_READ, 8'h00);
        send_request(psg_pkg::REQ_SELECT, 8'd15);
        send_request(psg_pkg::REQ_READ, 8'h00);
        write_chip(8'd200, 8'h55);
        send_request(psg_pkg::REQ_READ, 8'h00);
        write_chip(8'd8, 8'h1F);
        write_chip(8'd9, 8'h0F);
        write_chip(8'd13, 8'h0E);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
        send_request(psg_pkg::REQ_SAMPLE, 8'hFF);
    endtask

    task automatic test_settings();
        write_setting(psg_pkg::CFG_TICKS, 8'd0);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
        write_setting(psg_pkg::CFG_DIV, 8'd0);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
        write_setting(psg_pkg::CFG_TICKS, 8'd64);
        write_setting(psg_pkg::CFG_DIV, 8'd1);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
        write_setting(psg_pkg::CFG_DIV, 8'd255);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
        write_setting(psg_pkg::CFG_TICKS, 8'd1);
        send_request(psg_pkg::REQ_SAMPLE, 8'h00);
    endtask

    // Mostly select/write pairs with random content, reads and samples
    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                write_chip($urandom_range(99) < 90 ? 8'($urandom_range(15)) :
                           8'($urandom_range(255)), 8'($urandom_range(255)));
                n++;
            end else if (pick < 65) begin
                send_request(psg_pkg::REQ_SELECT, 8'($urandom_range(99) < 90 ?
                             $urandom_range(15) : $urandom_range(255)));
                send_request(psg_pkg::REQ_READ, 8'($urandom_range(255)));
                n++;
            end else if (pick < 70) begin
                send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                send_request(psg_pkg::REQ_SAMPLE, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_phase(input int idle_pct, input int stall_pct, input int count);
        idle_send_pct = idle_pct;
        stall_recv_pct = stall_pct;
        write_setting(psg_pkg::CFG_TICKS, 8'($urandom_range(1, 16)));
        write_setting(psg_pkg::CFG_DIV, 8'($urandom_range(1, 40)));
        test_random(count);
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        psg_result_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= stall_recv_pct);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d value=%0d",
                                 m_result_kind, m_result_value);
                end else begin
                    want = expected_results.pop_front();
                    if (want.kind == psg_pkg::KIND_READ) reads_seen++;
                    else samples_seen++;
                    if (want.kind !== m_result_kind || want.value !== m_result_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected kind=%0d value=%0d, got %0d/%0d",
                                     reads_seen + samples_seen, want.kind, want.value,
                                     m_result_kind, m_result_value);
                    end
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            (!s_valid && expected_results.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("psg_three_voice_sound_generator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = psg_pkg::REQ_SELECT;
        s_bus_value = 8'h00;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = psg_pkg::CFG_TICKS;
        cfg_data = 8'h00;
        mismatches = 0;
        reads_seen = 0;
        samples_seen = 0;
        idle_send_pct = 0;
        stall_recv_pct = 0;
        quiet_cycles = 0;
        build_shape_levels();
        reset_chip_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_settings();
        test_phase(0, 0, 450);
        test_phase(83, 0, 450);
        // hold off until every result is in
        wait_drained();
        test_phase(0, 83, 450);
        test_phase(29, 29, 450);
        stall_recv_pct = 0;
        wait_drained();
        $display("covered %0d register reads and %0d samples over four pacing phases",
                 reads_seen, samples_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("psg_three_voice_sound_generator: match");
        end else begin
            $display("psg_three_voice_sound_generator: mismatch");
        end
        $finish;
    end

endmodule
